[rtl/stuffed_frame_receiver_crc16_macros.svh]
// Assertion macros used by the frame receiver checker
`ifndef STUFFED_FRAME_RECEIVER_CRC16_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_CRC16_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst
`define SFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, sampled on clk, quiet during rst
`define SFR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/sfr_pkg.sv]
// Shared types, constants and the CRC step of the stuffed frame receiver
package sfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_END   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ESC   = 2'd2;

  // Reset values: STX, ETX, DLE
  localparam logic [BYTE_W-1:0] START_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_RST   = 8'h03;
  localparam logic [BYTE_W-1:0] ESC_RST   = 8'h10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_ESC,
    ST_CRCL,
    ST_CRCH,
    ST_EMIT
  } sfr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic begin_frame;
    logic store;
    logic hold_low;
    logic emit;
  } sfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic is_esc;
    logic full;
    logic crc_ok;
    logic last_issue;
  } sfr_status_t;

  // One byte of CRC-16-CCITT, MSB first
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

[rtl/sfr_if.sv]
// Handshake interfaces for received bytes, payload words and register writes
interface sfr_rx_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [POS_W-1:0]  byte_position;
  logic [LEN_W-1:0]  frame_length;
  logic              last_of_frame;
  modport source (output valid, output payload_byte, output byte_position,
                  output frame_length, output last_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input byte_position,
                  input frame_length, input last_of_frame, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  logic [BYTE_W-1:0]    wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/stuffed_frame_receiver_crc16.sv]
// Top level of the byte-stuffed frame receiver with CRC-16-CCITT check
//
//   channel  dir  handshake        word
//   cfg      in   valid/ready      reg_index, wr_data (start, end, escape code)
//   rx       in   valid/ready      rx_byte
//   res      out  valid/ready      payload_byte, byte_position, frame_length,
//                                  last_of_frame
//
// Received bytes are taken one a cycle while rx.ready is high; the CRC register
// advances a byte a cycle. After the second CRC byte of a good frame, rx.ready stays
// low while the frame store is read out one byte a cycle, unless res stalls.
// A stall on res holds the output register; rx is taken again as soon as the last
// byte has been read into it. rst is synchronous; the frame store is not cleared.
module stuffed_frame_receiver_crc16 #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sfr_cfg_if.sink   cfg,
  sfr_rx_if.sink    rx,
  sfr_res_if.source res
);
  import sfr_pkg::*;

  sfr_cmd_t    cmd;
  sfr_status_t status;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .res     (res),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

[rtl/sfr_ctrl.sv]
// Receive phase state machine: decodes each byte's role and sequences the emit
module sfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  sfr_pkg::sfr_status_t status,
  output sfr_pkg::sfr_cmd_t    cmd
);
  import sfr_pkg::*;

  sfr_state_t state;
  sfr_state_t state_next;
  logic       acc;

  assign rx_ready = (state != ST_EMIT);
  assign acc      = rx_valid && rx_ready;

  // Hold the phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance on each accepted byte, leave emit after the last read
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && status.is_start) state_next = ST_DATA;
      end
      ST_DATA: begin
        if (acc) begin
          if (status.is_start)    state_next = ST_DATA;
          else if (status.is_end) state_next = ST_CRCL;
          else if (status.is_esc) state_next = ST_ESC;
          else if (status.full)   state_next = ST_IDLE;
          else                    state_next = ST_DATA;
        end
      end
      ST_ESC: begin
        if (acc) state_next = status.full ? ST_IDLE : ST_DATA;
      end
      ST_CRCL: begin
        if (acc) state_next = ST_CRCH;
      end
      ST_CRCH: begin
        if (acc) state_next = status.crc_ok ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.last_issue) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        if (acc && status.is_start) state_next = ST_DATA;
      end
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.begin_frame = acc && status.is_start;
      end
      ST_DATA: begin
        cmd.begin_frame = acc && status.is_start;
        cmd.store       = acc && !status.is_start && !status.is_end &&
                          !status.is_esc && !status.full;
      end
      ST_ESC: begin
        cmd.store = acc && !status.full;
      end
      ST_CRCL: begin
        cmd.hold_low = acc;
      end
      ST_CRCH: begin
        cmd = '0;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd.begin_frame = acc && status.is_start;
      end
    endcase
  end

endmodule

[rtl/sfr_datapath.sv]
// Code registers, frame store, running CRC and the payload output register
module sfr_datapath #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
  sfr_cfg_if.sink                    cfg,
  sfr_res_if.source                  res,
  input  sfr_pkg::sfr_cmd_t          cmd,
  output sfr_pkg::sfr_status_t       status
);
  import sfr_pkg::*;

  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] start_code;
  logic [BYTE_W-1:0] end_code;
  logic [BYTE_W-1:0] escape_code;

  logic [BYTE_W-1:0] frame_store [MAX_PAYLOAD];
  logic [LEN_W-1:0]  byte_count;
  logic [CRC_W-1:0]  running_crc;
  logic [BYTE_W-1:0] crc_low_held;

  logic [POS_W-1:0]  rd_ptr;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_pos;
  logic [LEN_W-1:0]  out_len;
  logic              out_last;

  logic              issue;
  logic              last_rd;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code  <= START_RST;
      end_code    <= END_RST;
      escape_code <= ESC_RST;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_START: start_code  <= cfg.wr_data;
        REG_END:   end_code    <= cfg.wr_data;
        REG_ESC:   escape_code <= cfg.wr_data;
        default:   ;
      endcase
    end
  end

  // Byte role and frame checks
  assign status.is_start = (rx_byte == start_code);
  assign status.is_end   = (rx_byte == end_code);
  assign status.is_esc   = (rx_byte == escape_code);
  assign status.full     = (byte_count >= LEN_W'(MAX_PAYLOAD));
  assign status.crc_ok   = ({rx_byte, crc_low_held} == running_crc) && (byte_count != '0);

  // Count and CRC over the unescaped payload
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_crc  <= CRC_INIT;
      crc_low_held <= '0;
    end else begin
      if (cmd.begin_frame) begin
        byte_count  <= '0;
        running_crc <= CRC_INIT;
      end else if (cmd.store) begin
        byte_count  <= byte_count + LEN_W'(1);
        running_crc <= crc16_byte(running_crc, rx_byte);
      end
      if (cmd.hold_low) crc_low_held <= rx_byte;
    end
  end

  // Store payload bytes in arrival order
  always_ff @(posedge clk) begin
    if (cmd.store) frame_store[byte_count[ADDR_W-1:0]] <= rx_byte;
  end

  // During emit, read one stored byte whenever the output register is free or draining
  assign issue             = cmd.emit && (!out_valid || res.ready);
  assign last_rd           = (LEN_W'(rd_ptr) + LEN_W'(1)) == byte_count;
  assign status.last_issue = issue && last_rd;

  always_ff @(posedge clk) begin
    if (rst || !cmd.emit) begin
      rd_ptr <= '0;
    end else if (issue) begin
      rd_ptr <= rd_ptr + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_byte <= frame_store[rd_ptr[ADDR_W-1:0]];
      out_pos  <= rd_ptr;
      out_len  <= byte_count;
      out_last <= last_rd;
    end
  end

  assign res.valid         = out_valid;
  assign res.payload_byte  = out_byte;
  assign res.byte_position = out_pos;
  assign res.frame_length  = out_len;
  assign res.last_of_frame = out_last;

endmodule

[rtl/sfr_checker.sv]
// Port-level checks on the frame receiver, bound to its top level
`include "stuffed_frame_receiver_crc16_macros.svh"

module sfr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [sfr_pkg::BYTE_W-1:0] payload_byte,
  input logic [sfr_pkg::POS_W-1:0]  byte_position,
  input logic [sfr_pkg::LEN_W-1:0]  frame_length,
  input logic                       last_of_frame
);
  import sfr_pkg::*;

  logic [BYTE_W+POS_W:0] res_word;
  logic [LEN_W-1:0]      pos_end;
  logic [POS_W-1:0]      pos_next;
  logic                  mid_taken;

  // Word fields seen as one value, and the positions around the current one
  assign res_word  = {payload_byte, byte_position, last_of_frame};
  assign pos_end   = LEN_W'(byte_position) + LEN_W'(1);
  assign pos_next  = byte_position + POS_W'(1);
  assign mid_taken = res_valid && res_ready && !last_of_frame;

  // A stalled word holds
  `SFR_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word))

  // The last word sits at the end of the frame
  `SFR_ASSERT_IMP(a_last_pos, res_valid && last_of_frame, pos_end == frame_length)

  // Any other word lies inside the frame
  `SFR_ASSERT_IMP(a_mid_pos, res_valid && !last_of_frame, pos_end < frame_length)

  // A taken word that is not the last is followed by its successor
  `SFR_ASSERT_NXT(a_next_pos, mid_taken, !res_valid || byte_position == $past(pos_next))

endmodule

bind stuffed_frame_receiver_crc16 sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .payload_byte  (res.payload_byte),
  .byte_position (res.byte_position),
  .frame_length  (res.frame_length),
  .last_of_frame (res.last_of_frame)
);
